>>> hw/rtl/voxel_world_coordinate_map_core_defines.svh
// Assertion macros for the voxel/world coordinate map core.
// Depends on nothing; users supply i_clk and i_rst_n in scope.
`ifndef VOXEL_WORLD_COORDINATE_MAP_CORE_DEFINES_SVH
`define VOXEL_WORLD_COORDINATE_MAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VWCM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define VWCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define VWCM_ASSERT(lbl, cond, msg)
`define VWCM_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/vwcm_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions of the voxel/world coordinate map core.
// Depends on nothing.
package vwcm_pkg;

    localparam int IDX_W     = 12;
    localparam int GSZ_W     = 3 * IDX_W;
    localparam int DIV_W     = 49;           // |diff| << 16
    localparam int DIV_STEPS = DIV_W;        // one quotient bit per stage
    localparam logic [15:0] HALF_BIAS = 16'd32702;
    localparam logic [DIV_W-1:0] NEG_CLAMP = DIV_W'(98238);

    // Register indexes
    localparam logic [2:0] REG_ORG_A = 3'd0;
    localparam logic [2:0] REG_ORG_B = 3'd1;
    localparam logic [2:0] REG_ORG_C = 3'd2;
    localparam logic [2:0] REG_STP_A = 3'd3;
    localparam logic [2:0] REG_STP_B = 3'd4;
    localparam logic [2:0] REG_STP_C = 3'd5;
    localparam logic [2:0] REG_GSZ   = 3'd6;
    localparam logic [2:0] REG_AMAP  = 3'd7;

    // Axis codes
    localparam logic [1:0] AX_X   = 2'd0;
    localparam logic [1:0] AX_Y   = 2'd1;
    localparam logic [1:0] AX_Z   = 2'd2;
    localparam logic [1:0] AX_BAD = 2'd3;

    localparam logic OP_TO_WORLD = 1'b0;
    localparam logic OP_TO_INDEX = 1'b1;

    // One divider lane
    typedef struct packed {
        logic [DIV_W-1:0] dq;    // dividend bits out, quotient bits in
        logic [31:0]      rem;
        logic [31:0]      dvs;
        logic             neg;
        logic             zero;
    } t_lane;

    // Values that ride along with the divider
    typedef struct packed {
        logic        op;
        logic        bad;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
    } t_side;

    // Saturate a 46-bit signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic [45:0] v);
        logic [31:0] r;
        if (!v[45] && (|v[44:31])) begin
            r = 32'h7FFF_FFFF;
        end else if (v[45] && !(&v[44:31])) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Pick the world value a grid axis reads
    function automatic logic [31:0] sel_world(input logic [1:0] code, input logic [31:0] wx,
                                              input logic [31:0] wy, input logic [31:0] wz);
        logic [31:0] r;
        case (code)
            AX_X:    r = wx;
            AX_Y:    r = wy;
            AX_Z:    r = wz;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // One restoring division step
    function automatic t_lane div_step(input t_lane l);
        t_lane       o;
        logic [32:0] t;
        logic [32:0] s;
        o = l;
        t = {l.rem, l.dq[DIV_W-1]};
        s = t - {1'b0, l.dvs};
        if (!s[32]) begin
            o.rem = s[31:0];
            o.dq  = {l.dq[DIV_W-2:0], 1'b1};
        end else begin
            o.rem = t[31:0];
            o.dq  = {l.dq[DIV_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> hw/rtl/voxel_world_coordinate_map_core.sv
`timescale 1ns / 1ps
// Voxel index / world millimetre converter, Q16.16, with an APB register file.
// Depends on vwcm_pkg and voxel_world_coordinate_map_core_defines.svh.
//
// The core takes one item per cycle unless the result side stalls, and returns
// one result per item in order. An item passes 52 register stages: one
// multiply/subtract stage, one saturate and axis-permute stage, 49 stages of a
// restoring divider (one quotient bit each, three lanes, one per grid axis) and
// the output register. The divider depth sets the latency. Opcode 0 items ride
// through the same stages. A stall on the result side freezes the whole
// pipeline; no item is lost or repeated.
// Registers sit at byte address 8*i, 64-bit data; write them only when idle.
`include "voxel_world_coordinate_map_core_defines.svh"
module voxel_world_coordinate_map_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // index_a, index_b, index_c, world_x, world_y, world_z, 4 zero bits
    input  logic [135:0] s_axis_tdata,
    // opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_x, result_y, result_z, result_a, result_b, result_c, clamped,
    // orient_bad, 2 zero bits
    output logic [135:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import vwcm_pkg::*;

    logic [31:0]      r_org [3];
    logic [31:0]      r_stp [3];
    logic [GSZ_W-1:0] r_gsz;
    logic [5:0]       r_amap;

    logic w_adv;
    logic w_cfg_wr;
    logic [1:0] w_code [3];
    logic w_bad;

    // Register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= 32'd0;
            r_org[1] <= 32'd0;
            r_org[2] <= 32'd0;
            r_stp[0] <= 32'd65536;
            r_stp[1] <= 32'd65536;
            r_stp[2] <= 32'd65536;
            r_gsz    <= GSZ_W'(36'h0FF0FF0FF);
            r_amap   <= 6'd36;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                REG_ORG_A: r_org[0] <= pwdata[31:0];
                REG_ORG_B: r_org[1] <= pwdata[31:0];
                REG_ORG_C: r_org[2] <= pwdata[31:0];
                REG_STP_A: r_stp[0] <= pwdata[31:0];
                REG_STP_B: r_stp[1] <= pwdata[31:0];
                REG_STP_C: r_stp[2] <= pwdata[31:0];
                REG_GSZ:   r_gsz    <= pwdata[GSZ_W-1:0];
                REG_AMAP:  r_amap   <= pwdata[5:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_ORG_A: prdata = {32'd0, r_org[0]};
            REG_ORG_B: prdata = {32'd0, r_org[1]};
            REG_ORG_C: prdata = {32'd0, r_org[2]};
            REG_STP_A: prdata = {32'd0, r_stp[0]};
            REG_STP_B: prdata = {32'd0, r_stp[1]};
            REG_STP_C: prdata = {32'd0, r_stp[2]};
            REG_GSZ:   prdata = {{(64-GSZ_W){1'b0}}, r_gsz};
            REG_AMAP:  prdata = {58'd0, r_amap};
            default:   prdata = 64'd0;
        endcase
    end

    assign w_code[0] = r_amap[1:0];
    assign w_code[1] = r_amap[3:2];
    assign w_code[2] = r_amap[5:4];
    assign w_bad = (w_code[0] == AX_BAD) || (w_code[1] == AX_BAD) || (w_code[2] == AX_BAD);

    // Whole pipeline advances unless the output holds an untaken item
    logic r_ovld;
    assign w_adv         = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Stage 1: multiply index by step, subtract origin from world value
    logic [IDX_W-1:0] w_idx [3];
    logic [31:0]      w_wld [3];
    logic [31:0]      w_sel [3];
    assign w_idx[0] = s_axis_tdata[11:0];
    assign w_idx[1] = s_axis_tdata[23:12];
    assign w_idx[2] = s_axis_tdata[35:24];
    assign w_wld[0] = s_axis_tdata[67:36];
    assign w_wld[1] = s_axis_tdata[99:68];
    assign w_wld[2] = s_axis_tdata[131:100];

    // Route each grid axis to the world value it reads
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_sel[g] = sel_world(w_code[g], w_wld[0], w_wld[1], w_wld[2]);
        end
    end

    logic        r_s1_vld;
    logic        r_s1_op;
    logic [44:0] r_s1_prod [3];
    logic [32:0] r_s1_diff [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op <= s_axis_tuser;
            for (int g = 0; g < 3; g++) begin
                r_s1_prod[g] <= $signed({1'b0, w_idx[g]}) * $signed(r_stp[g]);
                r_s1_diff[g] <= {w_sel[g][31], w_sel[g]} - {r_org[g][31], r_org[g]};
            end
        end
    end

    // Stage 2: saturate and permute for opcode 0, set up divider lanes for opcode 1
    logic        r_vld [DIV_STEPS+1];
    t_lane       r_ln  [DIV_STEPS+1][3];
    t_side       r_sd  [DIV_STEPS+1];
    t_side       w_s2_sd;
    t_lane       w_s2_ln [3];
    logic [31:0] w_mm    [3];

    always_comb begin
        w_s2_sd.op  = r_s1_op;
        w_s2_sd.bad = w_bad;
        w_s2_sd.rx  = 32'd0;
        w_s2_sd.ry  = 32'd0;
        w_s2_sd.rz  = 32'd0;
        for (int g = 0; g < 3; g++) begin
            w_mm[g] = sat32({{14{r_org[g][31]}}, r_org[g]}
                            + {r_s1_prod[g][44], r_s1_prod[g]});
            // later grid axis wins a shared world axis
            case (w_code[g])
                AX_X:    w_s2_sd.rx = w_mm[g];
                AX_Y:    w_s2_sd.ry = w_mm[g];
                AX_Z:    w_s2_sd.rz = w_mm[g];
                default: ;
            endcase
            w_s2_ln[g].neg  = r_s1_diff[g][32] ^ r_stp[g][31];
            w_s2_ln[g].zero = (r_stp[g] == 32'd0);
            w_s2_ln[g].rem  = 32'd0;
            w_s2_ln[g].dvs  = r_stp[g][31] ? (32'd0 - r_stp[g]) : r_stp[g];
            w_s2_ln[g].dq   = {(r_s1_diff[g][32] ? (33'd0 - r_s1_diff[g]) : r_s1_diff[g]),
                               16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= w_s2_sd;
            for (int g = 0; g < 3; g++) begin
                r_ln[0][g] <= w_s2_ln[g];
            end
        end
    end

    // Divider stages: one quotient bit per stage per lane
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sd[k+1] <= r_sd[k];
                for (int g = 0; g < 3; g++) begin
                    r_ln[k+1][g] <= div_step(r_ln[k][g]);
                end
            end
        end
    end

    // Final stage: bias, truncate and clamp the quotients
    t_side            w_fs;
    logic [IDX_W-1:0] w_lim [3];
    logic [IDX_W-1:0] w_res [3];
    logic [DIV_W:0]   w_sum [3];
    logic [DIV_W-16:0] w_v  [3];
    logic             w_clamp;

    assign w_fs     = r_sd[DIV_STEPS];
    assign w_lim[0] = r_gsz[IDX_W-1:0];
    assign w_lim[1] = r_gsz[2*IDX_W-1:IDX_W];
    assign w_lim[2] = r_gsz[3*IDX_W-1:2*IDX_W];

    always_comb begin
        w_clamp = 1'b0;
        for (int g = 0; g < 3; g++) begin
            w_sum[g] = {1'b0, r_ln[DIV_STEPS][g].dq} + (DIV_W+1)'(HALF_BIAS);
            w_v[g]   = w_sum[g][DIV_W:16];
            w_res[g] = '0;
            if (w_fs.op == OP_TO_INDEX) begin
                if (r_ln[DIV_STEPS][g].zero) begin
                    w_clamp = 1'b1;
                end else if (r_ln[DIV_STEPS][g].neg) begin
                    // small negative quotients truncate to zero unflagged
                    if (r_ln[DIV_STEPS][g].dq >= NEG_CLAMP) begin
                        w_clamp = 1'b1;
                    end
                end else if (w_v[g] > (DIV_W-15)'(w_lim[g])) begin
                    w_res[g] = w_lim[g];
                    w_clamp  = 1'b1;
                end else begin
                    w_res[g] = w_v[g][IDX_W-1:0];
                end
            end
        end
    end

    // Output register
    logic [135:0] r_otd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_otd <= {2'b00, w_fs.bad, w_clamp, w_res[2], w_res[1], w_res[0],
                      (w_fs.op == OP_TO_WORLD) ? w_fs.rz : 32'd0,
                      (w_fs.op == OP_TO_WORLD) ? w_fs.ry : 32'd0,
                      (w_fs.op == OP_TO_WORLD) ? w_fs.rx : 32'd0};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_otd;

    // Checks
    `VWCM_ASSERT(a_idx_in_range, !m_axis_tvalid || (m_axis_tdata[107:96] <= r_gsz[11:0]), "index a beyond grid size")
    `VWCM_ASSERT_IMP(a_orient_flag, m_axis_tvalid, m_axis_tdata[133] == w_bad, "orientation flag disagrees with axis map")
    `VWCM_ASSERT_IMP(a_clamp_no_world, m_axis_tvalid && m_axis_tdata[132], m_axis_tdata[95:0] == 96'd0, "clamp flag with world output")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for voxel_world_coordinate_map_core: directed table, then random items.
// Depends on vwcm_pkg and the core; predicts each result in-bench and compares field by field.
module tb_top;
    import vwcm_pkg::*;

    typedef struct packed {
        logic        op;
        logic [11:0] ia, ib, ic;
        logic [31:0] wx, wy, wz;
    } t_item;

    typedef struct packed {
        logic [31:0] rx, ry, rz;
        logic [11:0] ra, rb, rc;
        logic        clamp, bad;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    voxel_world_coordinate_map_core uut (.*);

    always #5 i_clk = ~i_clk;

    // Configuration shadow
    logic signed [31:0] org [3];
    logic signed [31:0] stp [3];
    logic [35:0]        gsz;
    logic [5:0]         amap;

    t_res   exp_q [$];
    int     errors = 0;
    int     n_res = 0;
    int     idle_cycles = 0;
    bit     rx_hold = 1'b0;
    bit     rx_random = 1'b1;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expected conversion for one item under the current configuration
    function automatic t_res convert(input t_item it);
        t_res r;
        logic [1:0] code;
        logic [11:0] idx [3];
        logic signed [31:0] wv [3];
        logic signed [63:0] mm, q, v, lim;
        r = '0;
        idx[0] = it.ia; idx[1] = it.ib; idx[2] = it.ic;
        wv[0] = it.wx; wv[1] = it.wy; wv[2] = it.wz;
        for (int g = 0; g < 3; g++) begin
            code = amap[2*g +: 2];
            if (code == AX_BAD) r.bad = 1'b1;
            if (it.op == OP_TO_WORLD) begin
                mm = clip32(64'(signed'(org[g])) + $signed({52'd0, idx[g]}) * stp[g]);
                case (code)
                    AX_X: r.rx = mm[31:0];
                    AX_Y: r.ry = mm[31:0];
                    AX_Z: r.rz = mm[31:0];
                    default: ;
                endcase
            end else begin
                lim = $signed({52'd0, gsz[12*g +: 12]});
                mm = (code == AX_BAD) ? 64'sd0 : 64'(wv[code]);
                if (stp[g] == 0) begin
                    v = 0; r.clamp = 1'b1;
                end else begin
                    q = ((mm - org[g]) * 64'sd65536) / stp[g];
                    v = (q + 64'sd32702) / 64'sd65536;
                    if (v < 0) begin
                        v = 0; r.clamp = 1'b1;
                    end else if (v > lim) begin
                        v = lim; r.clamp = 1'b1;
                    end
                end
                case (g)
                    0: r.ra = v[11:0];
                    1: r.rb = v[11:0];
                    default: r.rc = v[11:0];
                endcase
            end
        end
        return r;
    endfunction

    // Write one register over APB and mirror it
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = {idx, 3'b000}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_ORG_A: org[0] = val[31:0];
            REG_ORG_B: org[1] = val[31:0];
            REG_ORG_C: org[2] = val[31:0];
            REG_STP_A: stp[0] = val[31:0];
            REG_STP_B: stp[1] = val[31:0];
            REG_STP_C: stp[2] = val[31:0];
            REG_GSZ:   gsz = val[35:0];
            default:   amap = val[5:0];
        endcase
    endtask

    // Offer one item, with an optional random gap first
    task automatic send_item(input t_item it, input bit gaps);
        int gap;
        gap = 0;
        if (gaps) gap = ($urandom_range(9) == 0) ? $urandom_range(30) :
                        ($urandom_range(2) == 0 ? $urandom_range(2) : 0);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.op;
        s_axis_tdata = {4'd0, it.wz, it.wy, it.wx, it.ic, it.ib, it.ia};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_q.push_back(convert(it));
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_item rand_item(input bit well);
        t_item it;
        it.op = 1'($urandom_range(1));
        it.ia = 12'($urandom); it.ib = 12'($urandom); it.ic = 12'($urandom);
        if (well && $urandom_range(3) != 0) begin
            it.ia = 12'($urandom_range(gsz[11:0]));
            it.ib = 12'($urandom_range(gsz[23:12]));
            it.ic = 12'($urandom_range(gsz[35:24]));
        end
        // world values mostly near the grid when well is set, sometimes anywhere
        if (well && $urandom_range(3) != 0) begin
            it.wx = $signed($urandom_range(600 << 16)) - (40 << 16);
            it.wy = $signed($urandom_range(600 << 16)) - (40 << 16);
            it.wz = $signed($urandom_range(600 << 16)) - (40 << 16);
        end else begin
            it.wx = $urandom; it.wy = $urandom; it.wz = $urandom;
        end
        return it;
    endfunction

    // Result side: random stall, long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold || !i_rst_n) m_axis_tready <= 1'b0;
        else if (!rx_random) m_axis_tready <= 1'b1;
        else if ($urandom_range(19) == 0) m_axis_tready <= 1'b0;
        else if (!m_axis_tready) m_axis_tready <= ($urandom_range(3) == 0);
        else m_axis_tready <= ($urandom_range(5) != 0);
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rx    = m_axis_tdata[31:0];
            got.ry    = m_axis_tdata[63:32];
            got.rz    = m_axis_tdata[95:64];
            got.ra    = m_axis_tdata[107:96];
            got.rb    = m_axis_tdata[119:108];
            got.rc    = m_axis_tdata[131:120];
            got.clamp = m_axis_tdata[132];
            got.bad   = m_axis_tdata[133];
            n_res++;
            if (exp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = exp_q.pop_front();
                if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz) begin
                    errors++;
                    $display("%0t: world xyz exp %h %h %h got %h %h %h", $time,
                             want.rx, want.ry, want.rz, got.rx, got.ry, got.rz);
                end
                if (got.ra !== want.ra || got.rb !== want.rb || got.rc !== want.rc) begin
                    errors++;
                    $display("%0t: index abc exp %h %h %h got %h %h %h", $time,
                             want.ra, want.rb, want.rc, got.ra, got.rb, got.rc);
                end
                if (got.clamp !== want.clamp || got.bad !== want.bad) begin
                    errors++;
                    $display("%0t: clamp/bad exp %b%b got %b%b", $time,
                             want.clamp, want.bad, got.clamp, got.bad);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item and no taken result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Directed rows: item, typed expectation (only when have_exp)
    typedef struct {
        t_item it;
        bit    have_exp;
        t_res  res;
    } t_row;

    t_row rows [$];

    function automatic t_row row(input t_item it, input bit he, input t_res r);
        t_row x;
        x.it = it; x.have_exp = he; x.res = r;
        return x;
    endfunction

    initial begin
        t_item it;
        t_res  got;
        logic [63:0] cfg;
        org[0] = 0; org[1] = 0; org[2] = 0;
        stp[0] = 65536; stp[1] = 65536; stp[2] = 65536;
        gsz = 36'h0FF0FF0FF; amap = 6'd36;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: index = mm, identity map
        rows.push_back(row('{OP_TO_WORLD, 12'd0, 12'd0, 12'd0, 0, 0, 0}, 1, '0));
        rows.push_back(row('{OP_TO_WORLD, 12'd1, 12'd2, 12'd3, 0, 0, 0}, 1,
                           '{32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0, 0}));
        rows.push_back(row('{OP_TO_WORLD, 12'hFFF, 12'hFFF, 12'hFFF, 0, 0, 0}, 1,
                           '{32'hFFF0000, 32'hFFF0000, 32'hFFF0000, 0, 0, 0, 0, 0}));
        rows.push_back(row('{OP_TO_INDEX, 12'hFFF, 0, 0, 32'h50000, 32'h7F8000, 0}, 1,
                           '{0, 0, 0, 12'd5, 12'd127, 12'd0, 1'b0, 1'b0}));
        rows.push_back(row('{OP_TO_INDEX, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF8000},
                           1, '{0, 0, 0, 12'd255, 12'd0, 12'd0, 1'b1, 1'b0}));
        rows.push_back(row('{OP_TO_INDEX, 0, 0, 0, 32'hFFFF0000, 32'hFFFF7FFF, 32'h00008000},
                           0, '0));
        foreach (rows[k]) begin
            send_item(rows[k].it, 1'b0);
            if (rows[k].have_exp && exp_q[$] !== rows[k].res) begin
                errors++;
                $display("%0t: table row %0d exp %h predicted %h", $time, k,
                         rows[k].res, exp_q[$]);
            end
        end
        drain();

        // Extremes: saturation, shared axes, bad code, zero step
        reg_write(REG_ORG_A, 64'h7FFF0000);
        reg_write(REG_ORG_B, 64'h80000000);
        reg_write(REG_ORG_C, 64'hFFFFFFFF_00000000);
        reg_write(REG_STP_A, 64'h7FFFFFFF);
        reg_write(REG_STP_B, 64'h80000000);
        reg_write(REG_STP_C, 64'd0);
        reg_write(REG_GSZ, 64'hF_FFFF_FFFF);
        reg_write(REG_AMAP, 64'd0);
        for (int k = 0; k < 8; k++) begin
            it = rand_item(k[0]);
            it.op = k[1];
            send_item(it, 1'b0);
        end
        drain();
        reg_write(REG_AMAP, 64'h3F);
        reg_write(REG_GSZ, 64'd0);
        for (int k = 0; k < 6; k++) send_item(rand_item(k[0]), 1'b0);
        drain();
        reg_write(REG_AMAP, 64'b10_11_01);
        reg_write(REG_STP_B, 64'hFFFF0000);
        for (int k = 0; k < 6; k++) send_item(rand_item(1'b1), 1'b0);
        drain();

        // Random phases under varied settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 8; r++) begin
                cfg = {$urandom, $urandom};
                case ($urandom_range(3))
                    0: cfg = {32'd0, 32'(signed'($urandom_range(40 << 16)) - (20 << 16))};
                    1: cfg = {32'd0, 32'($urandom_range(3 << 16) + 1)};
                    default: ;
                endcase
                if (r == REG_GSZ && $urandom_range(1))
                    cfg = {$urandom_range(300), $urandom_range(300)} & 64'hFFF_FFF;
                if (r == REG_AMAP && $urandom_range(3) != 0) cfg = 64'b10_01_00;
                reg_write(r[2:0], cfg);
            end
            if (ph == 3) begin
                // Long receiver hold-off while items keep coming
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                    for (int n = 0; n < 110; n++) send_item(rand_item(1'b1), 1'b0);
                join
            end else begin
                rx_random = (ph != 5);
                for (int n = 0; n < 105; n++) send_item(rand_item($urandom_range(4) != 0),
                                                         ph != 5);
            end
            drain();
        end

        $display("Covered directed extremes, saturation, axis sharing, bad map, zero step,");
        $display("and %0d results over random settings with stalls and backpressure.", n_res);
        if (errors == 0 && exp_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
